// File: rtl/core/sv39ptw_pkg.sv
// Shared types and constants for the Sv39 page-table walker.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package sv39ptw_pkg;

   localparam int VA_W     = 39;
   localparam int SLOT_W   = 13;
   localparam int WORD_W   = 64;
   localparam int PPN_W    = 44;
   localparam int PHYS_W   = 56;
   localparam int IDX_W    = 9;
   localparam int OFFS_W   = 12;
   localparam int STATUS_W = 2;
   // wide enough for any store address at the top of the page-count range
   localparam int ADDR_EXT_W = 20;

   localparam logic MODE_WRITE     = 1'b0;
   localparam logic MODE_TRANSLATE = 1'b1;

   localparam logic CSR_ROOT_PAGE   = 1'b0;
   localparam logic CSR_WINDOW_BASE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ADDR_HIGH  = 2'd1,
      STATUS_INVALID    = 2'd2,
      STATUS_OUT_WINDOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_FINISH
   } walk_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

// File: rtl/core/sv39ptw_req_if.sv
// Request channel: valid/ready handshake with the walker's input payload.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic [sv39ptw_pkg::VA_W-1:0]      virt_addr;
   logic [sv39ptw_pkg::SLOT_W-1:0]    entry_slot;
   logic [sv39ptw_pkg::WORD_W-1:0]    entry_word;

   modport source (output valid, mode, virt_addr, entry_slot, entry_word, input ready);
   modport sink   (input valid, mode, virt_addr, entry_slot, entry_word, output ready);
endinterface

// File: rtl/core/sv39ptw_rsp_if.sv
// Response channel: valid/ready handshake with the walker's result payload.
// Depends on sv39ptw_pkg for the field widths.
interface sv39ptw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sv39ptw_pkg::STATUS_W-1:0]  status;
   logic [sv39ptw_pkg::PHYS_W-1:0]    phys_addr;

   modport source (output valid, status, phys_addr, input ready);
   modport sink   (input valid, status, phys_addr, output ready);
endinterface

// File: rtl/core/sv39ptw_store.sv
// Page-table word store: one write port, one registered read port, and a
// zeroing sweep after reset. Depends on sv39ptw_pkg.
module sv39ptw_store #(
   parameter int TABLE_PAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sv39ptw_pkg::store_ctl_type          ctl,
   input  logic [$clog2(TABLE_PAGES*512)-1:0]  wr_addr,
   input  logic [sv39ptw_pkg::WORD_W-1:0]      wr_data,
   input  logic [$clog2(TABLE_PAGES*512)-1:0]  rd_addr,
   output logic [sv39ptw_pkg::WORD_W-1:0]      rd_data,
   output logic                                clear_busy
);

   localparam int WORDS = TABLE_PAGES * 512;
   localparam int AW    = $clog2(WORDS);

   logic [sv39ptw_pkg::WORD_W-1:0] mem [WORDS];

   logic [AW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic                           clearing_ff, clearing_in;
   logic                           mem_we;
   logic [AW-1:0]                  mem_addr;
   logic [sv39ptw_pkg::WORD_W-1:0] mem_data;
   logic [sv39ptw_pkg::WORD_W-1:0] rd_data_ff;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // sweep owns the write port until the last word is zeroed
   always_comb begin
      mem_we   = clearing_ff | ctl.wr_en;
      mem_addr = clearing_ff ? clr_cnt_ff : wr_addr;
      mem_data = clearing_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clearing_ff;

endmodule

// File: rtl/core/sv39_page_table_walker_top.sv
// Sv39 page-table walker. A translate passes through a start state that checks the
// request and issues the root read, up to three read states that each take one
// dependent read of the table store, and a finish state that loads the result register.
// A write goes from the start state straight to the finish state. One transaction is in
// the walker at a time; the next is taken the cycle after the result register is loaded.
// After reset the store's TABLE_PAGES*512 words are zeroed while req ready is held low.
module sv39_page_table_walker_top #(
   parameter int TABLE_PAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   sv39ptw_req_if.sink                     req_bus,
   sv39ptw_rsp_if.source                   rsp_bus,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [sv39ptw_pkg::PPN_W-1:0]   csr_wr_data
);

   localparam int WORDS = TABLE_PAGES * 512;
   localparam int AW    = $clog2(WORDS);
   localparam int EW    = sv39ptw_pkg::ADDR_EXT_W;

   sv39ptw_pkg::walk_state_type state_ff, state_in;

   logic [sv39ptw_pkg::PPN_W-1:0]   root_ff, base_ff;
   logic                            mode_ff;
   logic [sv39ptw_pkg::VA_W-1:0]    va_ff;
   logic [sv39ptw_pkg::SLOT_W-1:0]  slot_ff;
   logic [sv39ptw_pkg::WORD_W-1:0]  word_ff;
   logic [1:0]                      level_ff, level_in;
   sv39ptw_pkg::status_type         res_status_ff, res_status_in;
   logic [sv39ptw_pkg::PHYS_W-1:0]  res_phys_ff, res_phys_in;

   logic                            rsp_valid_ff;
   sv39ptw_pkg::status_type         rsp_status_ff;
   logic [sv39ptw_pkg::PHYS_W-1:0]  rsp_phys_ff;

   sv39ptw_pkg::store_ctl_type      store_ctl;
   logic [AW-1:0]                   wr_addr, rd_addr;
   logic [sv39ptw_pkg::WORD_W-1:0]  rd_data;
   logic                            clear_busy;

   logic                            req_take;
   logic                            rsp_free;
   logic                            slot_ok;
   logic [sv39ptw_pkg::PPN_W-1:0]   pg_sel, rel;
   logic                            in_win;
   logic [sv39ptw_pkg::IDX_W-1:0]   idx_sel;
   logic [EW-1:0]                   rd_addr_ext, wr_addr_ext;
   logic [sv39ptw_pkg::PPN_W-1:0]   pte_ppn;

   sv39ptw_store #(.TABLE_PAGES(TABLE_PAGES)) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (store_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (word_ff),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   assign req_bus.ready = (state_ff == sv39ptw_pkg::ST_IDLE) && !clear_busy;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign pte_ppn       = rd_data[53:10];

   // table page for the read to issue: root at the start, else the entry just read
   always_comb begin
      pg_sel  = (state_ff == sv39ptw_pkg::ST_START) ? root_ff : pte_ppn;
      rel     = pg_sel - base_ff;
      in_win  = (pg_sel >= base_ff) && (rel < sv39ptw_pkg::PPN_W'(TABLE_PAGES));
      if (state_ff == sv39ptw_pkg::ST_START) begin
         idx_sel = va_ff[38:30];
      end else if (level_ff == 2'd2) begin
         idx_sel = va_ff[29:21];
      end else begin
         idx_sel = va_ff[20:12];
      end
      rd_addr_ext = {rel[10:0], idx_sel};
      rd_addr     = rd_addr_ext[AW-1:0];
      wr_addr_ext = EW'(slot_ff);
      wr_addr     = wr_addr_ext[AW-1:0];
      slot_ok     = wr_addr_ext < EW'(WORDS);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sv39ptw_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = sv39ptw_pkg::ST_START;
            end
         end
         sv39ptw_pkg::ST_START: begin
            if (mode_ff == sv39ptw_pkg::MODE_WRITE || va_ff[38] || !in_win) begin
               state_in = sv39ptw_pkg::ST_FINISH;
            end else begin
               state_in = sv39ptw_pkg::ST_READ;
            end
         end
         sv39ptw_pkg::ST_READ: begin
            if (!rd_data[0] || level_ff == 2'd0 || !in_win) begin
               state_in = sv39ptw_pkg::ST_FINISH;
            end
         end
         sv39ptw_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = sv39ptw_pkg::ST_IDLE;
            end
         end
         default: state_in = sv39ptw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      store_ctl     = '0;
      level_in      = level_ff;
      res_status_in = res_status_ff;
      res_phys_in   = res_phys_ff;
      unique case (state_ff)
         sv39ptw_pkg::ST_IDLE: begin
         end
         sv39ptw_pkg::ST_START: begin
            level_in      = 2'd2;
            res_phys_in   = '0;
            res_status_in = sv39ptw_pkg::STATUS_OK;
            if (mode_ff == sv39ptw_pkg::MODE_WRITE) begin
               store_ctl.wr_en = slot_ok;
            end else if (va_ff[38]) begin
               res_status_in = sv39ptw_pkg::STATUS_ADDR_HIGH;
            end else if (!in_win) begin
               res_status_in = sv39ptw_pkg::STATUS_OUT_WINDOW;
            end else begin
               store_ctl.rd_en = 1'b1;
            end
         end
         sv39ptw_pkg::ST_READ: begin
            if (!rd_data[0]) begin
               res_status_in = sv39ptw_pkg::STATUS_INVALID;
            end else if (level_ff == 2'd0) begin
               res_status_in = sv39ptw_pkg::STATUS_OK;
               res_phys_in   = {pte_ppn, va_ff[sv39ptw_pkg::OFFS_W-1:0]};
            end else if (!in_win) begin
               res_status_in = sv39ptw_pkg::STATUS_OUT_WINDOW;
            end else begin
               store_ctl.rd_en = 1'b1;
               level_in        = level_ff - 2'd1;
            end
         end
         sv39ptw_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sv39ptw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         root_ff      <= '0;
         base_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == sv39ptw_pkg::ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               sv39ptw_pkg::CSR_ROOT_PAGE:   root_ff <= csr_wr_data;
               sv39ptw_pkg::CSR_WINDOW_BASE: base_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_bus.mode;
         va_ff   <= req_bus.virt_addr;
         slot_ff <= req_bus.entry_slot;
         word_ff <= req_bus.entry_word;
      end
      level_ff      <= level_in;
      res_status_ff <= res_status_in;
      res_phys_ff   <= res_phys_in;
      if (state_ff == sv39ptw_pkg::ST_FINISH && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_phys_ff   <= res_phys_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.phys_addr = rsp_phys_ff;

endmodule

// File: verif/tb_top.sv
// Self-checking bench for the Sv39 page-table walker: directed table, then random phases.
// Uses sv39ptw_pkg and both channel interfaces from rtl/core; predicts untyped walks locally.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VA_W   = sv39ptw_pkg::VA_W;
   localparam int SLOT_W = sv39ptw_pkg::SLOT_W;
   localparam int WORD_W = sv39ptw_pkg::WORD_W;
   localparam int PPN_W  = sv39ptw_pkg::PPN_W;
   localparam int PHYS_W = sv39ptw_pkg::PHYS_W;
   localparam int IDX_W  = sv39ptw_pkg::IDX_W;
   localparam int OFFS_W = sv39ptw_pkg::OFFS_W;

   localparam int TABLE_PAGES    = 16;
   localparam int WORDS_PER_PAGE = 512;
   localparam int STORE_WORDS    = TABLE_PAGES * WORDS_PER_PAGE;
   localparam int WALK_LATENCY   = 8;
   localparam int PHASE_ITEMS    = 205;
   localparam logic [PPN_W-1:0] PPN_MAX = {PPN_W{1'b1}};

   typedef struct {
      logic              mode;
      logic [VA_W-1:0]   virt_addr;
      logic [SLOT_W-1:0] entry_slot;
      logic [WORD_W-1:0] entry_word;
   } walk_req_type;

   typedef struct {
      sv39ptw_pkg::status_type status;
      logic [PHYS_W-1:0]       phys_addr;
   } walk_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      walk_req_type      req;
      bit                typed;
      walk_result_type   result;
      logic              csr_idx;
      logic [PPN_W-1:0]  csr_data;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [PPN_W-1:0] csr_wr_data;

   sv39ptw_req_if req_bus();
   sv39ptw_rsp_if rsp_bus();

   sv39_page_table_walker_top #(.TABLE_PAGES(TABLE_PAGES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the walker: table store and the two page registers
   logic [WORD_W-1:0] pte_mirror [STORE_WORDS];
   logic [PPN_W-1:0]  walk_root;
   logic [PPN_W-1:0]  walk_base;

   walk_result_type  pending_walks [$];
   directed_row_type directed_rows [$];
   int               mismatch_count;
   bit               calm;

   // tags that travel with the request payload
   bit                tag_typed;
   walk_result_type   tag_result;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(5_000_000);
      $display("FAIL sv39_page_table_walker_top");
      $finish;
   end

   function automatic void predict_walk(input walk_req_type it, output walk_result_type res);
      logic [PPN_W-1:0]  pg;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] pte;
      res.status    = sv39ptw_pkg::STATUS_OK;
      res.phys_addr = '0;
      if (it.mode == sv39ptw_pkg::MODE_WRITE) begin
         if (int'(it.entry_slot) < STORE_WORDS)
            pte_mirror[it.entry_slot] = it.entry_word;
         return;
      end
      if (it.virt_addr[VA_W-1]) begin
         res.status = sv39ptw_pkg::STATUS_ADDR_HIGH;
         return;
      end
      pg = walk_root;
      for (int lvl = 2; lvl >= 0; lvl--) begin
         idx = it.virt_addr[OFFS_W + IDX_W*lvl +: IDX_W];
         if (pg < walk_base || (pg - walk_base) >= PPN_W'(TABLE_PAGES)) begin
            res.status = sv39ptw_pkg::STATUS_OUT_WINDOW;
            return;
         end
         pte = pte_mirror[int'(pg - walk_base) * WORDS_PER_PAGE + int'(idx)];
         if (!pte[0]) begin
            res.status = sv39ptw_pkg::STATUS_INVALID;
            return;
         end
         pg = pte[PPN_W+9:10];
      end
      res.phys_addr = {pg, it.virt_addr[OFFS_W-1:0]};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic walk_req_type noise_item();
      walk_req_type it;
      logic [63:0] r;
      r = rand64();
      it.mode       = 1'($urandom_range(0, 1));
      it.virt_addr  = r[VA_W-1:0];
      it.entry_slot = SLOT_W'($urandom_range(0, 8191));
      it.entry_word = rand64();
      return it;
   endfunction

   function automatic logic [WORD_W-1:0] make_pte(input logic [PPN_W-1:0] ppn, input bit valid);
      logic [63:0] r;
      r = rand64();
      return {r[63:54], ppn, r[9:1], valid};
   endfunction

   function automatic int draw_idle();
      if (calm || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic void add_item(input logic mode, input logic [VA_W-1:0] va,
                                    input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word,
                                    input bit typed, input sv39ptw_pkg::status_type st,
                                    input logic [PHYS_W-1:0] pa);
      directed_row_type row;
      row.kind                 = ROW_ITEM;
      row.req.mode             = mode;
      row.req.virt_addr        = va;
      row.req.entry_slot       = slot;
      row.req.entry_word       = word;
      row.typed                = typed;
      row.result.status        = st;
      row.result.phys_addr     = pa;
      row.csr_idx              = sv39ptw_pkg::CSR_ROOT_PAGE;
      row.csr_data             = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic idx, input logic [PPN_W-1:0] data);
      directed_row_type row;
      row.kind     = ROW_CSR;
      row.req      = '{mode: sv39ptw_pkg::MODE_WRITE, virt_addr: '0, entry_slot: '0,
                       entry_word: '0};
      row.typed    = 1'b0;
      row.result   = '{status: sv39ptw_pkg::STATUS_OK, phys_addr: '0};
      row.csr_idx  = idx;
      row.csr_data = data;
      directed_rows.push_back(row);
   endfunction

   task automatic send_walk(input walk_req_type it, input bit typed, input walk_result_type res);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= it.mode;
      req_bus.virt_addr  <= it.virt_addr;
      req_bus.entry_slot <= it.entry_slot;
      req_bus.entry_word <= it.entry_word;
      tag_typed          <= typed;
      tag_result         <= res;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off until every outstanding transaction has answered
   task automatic drain_pause();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_walks.size() != 0);
      @(posedge clock);
   endtask

   task automatic settle();
      drain_pause();
      repeat (WALK_LATENCY) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [PPN_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      if (idx == sv39ptw_pkg::CSR_ROOT_PAGE)
         walk_root = data;
      else
         walk_base = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // three chained entries, then one or two walks through them
   task automatic map_sequence(input int span, input int root_rel, output int count);
      logic [IDX_W-1:0] idx2, idx1, idx0;
      logic [PPN_W-1:0] ptr1, ptr0, leaf;
      logic [63:0]      r;
      int               p1, p0, flaw, flaw_lvl, walks;
      walk_req_type     it;
      walk_result_type  none;
      none     = '{status: sv39ptw_pkg::STATUS_OK, phys_addr: '0};
      idx2     = IDX_W'($urandom_range(0, 255));
      idx1     = IDX_W'($urandom_range(0, 511));
      idx0     = IDX_W'($urandom_range(0, 511));
      p1       = $urandom_range(0, span - 1);
      p0       = $urandom_range(0, span - 1);
      ptr1     = walk_base + PPN_W'(p1);
      ptr0     = walk_base + PPN_W'(p0);
      r        = rand64();
      leaf     = ($urandom_range(0, 3) == 0) ? walk_base + PPN_W'(p0) : r[PPN_W-1:0];
      flaw     = $urandom_range(0, 7);
      flaw_lvl = $urandom_range(0, 2);
      if (flaw == 1) begin
         r = rand64();
         case ($urandom_range(0, 2))
            0:       r[PPN_W-1:0] = walk_base - 1'b1;
            1:       r[PPN_W-1:0] = walk_base + PPN_W'(span);
            default: ;
         endcase
         if (flaw_lvl == 2)
            ptr1 = r[PPN_W-1:0];
         else
            ptr0 = r[PPN_W-1:0];
      end
      it            = noise_item();
      it.mode       = sv39ptw_pkg::MODE_WRITE;
      it.entry_slot = SLOT_W'(root_rel * WORDS_PER_PAGE + int'(idx2));
      it.entry_word = make_pte(ptr1, !(flaw == 0 && flaw_lvl == 2));
      send_walk(it, 1'b0, none);
      it            = noise_item();
      it.mode       = sv39ptw_pkg::MODE_WRITE;
      it.entry_slot = SLOT_W'(p1 * WORDS_PER_PAGE + int'(idx1));
      it.entry_word = make_pte(ptr0, !(flaw == 0 && flaw_lvl == 1));
      send_walk(it, 1'b0, none);
      it            = noise_item();
      it.mode       = sv39ptw_pkg::MODE_WRITE;
      it.entry_slot = SLOT_W'(p0 * WORDS_PER_PAGE + int'(idx0));
      it.entry_word = make_pte(leaf, !(flaw == 0 && flaw_lvl == 0));
      send_walk(it, 1'b0, none);
      walks = $urandom_range(1, 2);
      for (int w = 0; w < walks; w++) begin
         it           = noise_item();
         it.mode      = sv39ptw_pkg::MODE_TRANSLATE;
         it.virt_addr = {idx2, idx1, idx0, OFFS_W'($urandom_range(0, 4095))};
         send_walk(it, 1'b0, none);
      end
      count = 3 + walks;
   endtask

   task automatic run_phase(input logic [PPN_W-1:0] base, input logic [PPN_W-1:0] root,
                            input bit quiet);
      int span, root_rel, sent, n;
      walk_result_type none;
      none = '{status: sv39ptw_pkg::STATUS_OK, phys_addr: '0};
      settle();
      write_csr(sv39ptw_pkg::CSR_WINDOW_BASE, base);
      write_csr(sv39ptw_pkg::CSR_ROOT_PAGE, root);
      calm = quiet;
      // keep chained pages inside the 44-bit page space
      span = (PPN_MAX - base >= PPN_W'(TABLE_PAGES - 1)) ? TABLE_PAGES
                                                         : int'(PPN_MAX - base) + 1;
      if (root >= base && (root - base) < PPN_W'(TABLE_PAGES))
         root_rel = int'(root - base);
      else
         root_rel = $urandom_range(0, span - 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(0, 39) == 0)
            drain_pause();
         if ($urandom_range(0, 4) != 0) begin
            map_sequence(span, root_rel, n);
            sent += n;
         end else begin
            send_walk(noise_item(), 1'b0, none);
            sent++;
         end
      end
   endtask

   // predict on acceptance, compare on delivery
   always @(posedge clock) begin : scoreboard
      walk_req_type    it;
      walk_result_type predicted;
      walk_result_type exp_r;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.mode       = req_bus.mode;
            it.virt_addr  = req_bus.virt_addr;
            it.entry_slot = req_bus.entry_slot;
            it.entry_word = req_bus.entry_word;
            predict_walk(it, predicted);
            if (tag_typed)
               pending_walks.push_back(tag_result);
            else
               pending_walks.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_walks.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, actual status %0d phys %h",
                        $time, rsp_bus.status, rsp_bus.phys_addr);
            end else begin
               exp_r = pending_walks.pop_front();
               if (rsp_bus.status !== exp_r.status) begin
                  mismatch_count++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, exp_r.status, rsp_bus.status);
               end
               if (rsp_bus.phys_addr !== exp_r.phys_addr) begin
                  mismatch_count++;
                  $display("%0t: phys_addr mismatch: expected %h, actual %h",
                           $time, exp_r.phys_addr, rsp_bus.phys_addr);
               end
            end
         end
      end
   end

   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      logic [PPN_W-1:0] base, root;
      logic [63:0]      r;
      directed_row_type row;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= sv39ptw_pkg::MODE_WRITE;
      req_bus.virt_addr  <= '0;
      req_bus.entry_slot <= '0;
      req_bus.entry_word <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= sv39ptw_pkg::CSR_ROOT_PAGE;
      csr_wr_data        <= '0;
      tag_typed          <= 1'b0;
      tag_result         <= '{status: sv39ptw_pkg::STATUS_OK, phys_addr: '0};
      mismatch_count      = 0;
      calm                = 1'b0;
      walk_root           = '0;
      walk_base           = '0;
      foreach (pte_mirror[i])
         pte_mirror[i] = '0;

      // reset settings: root page 0, window from page 0, store cleared
      add_item(sv39ptw_pkg::MODE_TRANSLATE, '0, '0, '0, 1, sv39ptw_pkg::STATUS_INVALID, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, 39'h40_0000_0000, '0, '0, 1,
               sv39ptw_pkg::STATUS_ADDR_HIGH, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, {VA_W{1'b1}}, '0, '0, 1,
               sv39ptw_pkg::STATUS_ADDR_HIGH, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, '0, {WORD_W{1'b1}}, 1, sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, '0, '0, '0, 1, sv39ptw_pkg::STATUS_OUT_WINDOW, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd0, {10'h0, 44'd1, 9'h0, 1'b1}, 1,
               sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd512, {10'h0, 44'd2, 9'h0, 1'b1}, 1,
               sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd1024, {10'h3FF, 44'hABC, 9'h1FF, 1'b1}, 1,
               sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, 39'hFFF, '0, '0, 0, sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd255, {10'h0, 44'd15, 9'h0, 1'b1}, 1,
               sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd8191, {10'h0, 44'd15, 9'h0, 1'b1}, 1,
               sv39ptw_pkg::STATUS_OK, '0);
      // highest address below the limit walks root index 255, then the last index of the lower levels
      add_item(sv39ptw_pkg::MODE_TRANSLATE, 39'h3F_FFFF_FFFF, '0, '0, 0,
               sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_WRITE, '0, 13'd1024, '0, 1, sv39ptw_pkg::STATUS_OK, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, 39'h5A5, '0, '0, 0, sv39ptw_pkg::STATUS_OK, '0);
      add_csr(sv39ptw_pkg::CSR_WINDOW_BASE, PPN_MAX - 44'd15);
      add_csr(sv39ptw_pkg::CSR_ROOT_PAGE, PPN_MAX);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, '0, '0, '0, 0, sv39ptw_pkg::STATUS_OK, '0);
      add_csr(sv39ptw_pkg::CSR_WINDOW_BASE, PPN_MAX);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, '0, '0, '0, 0, sv39ptw_pkg::STATUS_OK, '0);
      add_csr(sv39ptw_pkg::CSR_ROOT_PAGE, '0);
      add_item(sv39ptw_pkg::MODE_TRANSLATE, 39'h12345, '0, '0, 1,
               sv39ptw_pkg::STATUS_OUT_WINDOW, '0);

      do @(posedge clock); while (reset);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.csr_idx, row.csr_data);
         end else begin
            send_walk(row.req, row.typed, row.result);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         r = rand64();
         base = r[PPN_W-1:0];
         case (ph)
            0: begin
               base = '0;
               root = '0;
            end
            1: begin
               base = PPN_MAX - 44'd15;
               root = PPN_MAX;
            end
            2: begin
               base = PPN_MAX;
               root = PPN_MAX;
            end
            3: begin
               r    = rand64();
               root = r[PPN_W-1:0];
            end
            default: root = base + PPN_W'($urandom_range(0, TABLE_PAGES - 1));
         endcase
         run_phase(base, root, ph == 5);
      end

      settle();
      if (mismatch_count == 0)
         $display("PASS sv39_page_table_walker_top");
      else
         $display("FAIL sv39_page_table_walker_top");
      $finish;
   end

endmodule

// File: sv39_page_table_walker_top.f
rtl/core/sv39ptw_pkg.sv
rtl/core/sv39ptw_req_if.sv
rtl/core/sv39ptw_rsp_if.sv
rtl/core/sv39ptw_store.sv
rtl/core/sv39_page_table_walker_top.sv
verif/tb_top.sv
